// ===== rtl/cflvc_pkg.sv =====
// ----------------------------------------------------------------------------
// cflvc_pkg
// Types and constants shared by the CAN frame latest-value cache.
// ----------------------------------------------------------------------------
`default_nettype none
package cflvc_pkg;

  localparam int unsigned ID_W   = 29;
  localparam int unsigned DATA_W = 64;
  localparam int unsigned LEN_W  = 4;

  typedef enum logic [1:0] {
    OP_STORE = 2'd0,
    OP_RR    = 2'd1,
    OP_REQ   = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_NONE = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]        operation;
    logic [ID_W-1:0]   frame_id;
    logic              extended_format;
    logic [LEN_W-1:0]  length_code;
    logic [DATA_W-1:0] payload_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ID_W-1:0]   claimed_id;
    logic [DATA_W-1:0] claimed_payload;
  } out_item_t;

  // Command handed from the front end to the engine
  typedef struct packed {
    op_t               op;
    logic [ID_W-1:0]   frame_id;
    logic              ext;
    logic [DATA_W-1:0] data;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_WRITE,
    S_DONE
  } eng_state_t;

  // Keep the low len bytes of the payload, len already clamped to 8
  function automatic logic [DATA_W-1:0] mask_payload(logic [LEN_W-1:0] len,
                                                     logic [DATA_W-1:0] d);
    logic [DATA_W-1:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if (LEN_W'(b) < len) m[b*8 +: 8] = 8'hFF;
    end
    return d & m;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/can_frame_latest_value_cache_core.sv =====
// ----------------------------------------------------------------------------
// can_frame_latest_value_cache_core
// Latest-value cache of CAN frames with store, round-robin and requested claim.
// ----------------------------------------------------------------------------
//  channel   direction  ports
//  in        input      in_valid / in_ready / in_data
//  out       output     out_valid / out_ready / out_data
//
//  An item scanning m slots (m at most slots_used) raises out_valid after the
//  engine has passed scan, read, write and done (scan goes to done at once
//  for OP_NONE or an empty table); slot tags are read one at a time, each
//  registered before the compare; a new command waits for out_valid to clear.
//  A two-entry command queue lets the front take items while the engine works.
//  rst_n is synchronous; it clears queue, pending marks, fill count and cursor.
//  A stalled out_ready holds the result and the engine; the queue then fills.
`default_nettype none
module can_frame_latest_value_cache_core #(
  parameter int unsigned CACHE_DEPTH = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire cflvc_pkg::in_item_t  in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output cflvc_pkg::out_item_t      out_data
);
  import cflvc_pkg::*;

  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  cflvc_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .cmd_valid, .cmd_ready, .cmd
  );

  cflvc_engine #(.CACHE_DEPTH(CACHE_DEPTH)) u_engine (
    .clk, .rst_n, .cmd_valid, .cmd_ready, .cmd,
    .out_valid, .out_ready, .out_data
  );

endmodule
`default_nettype wire

// ===== rtl/cflvc_front.sv =====
// ----------------------------------------------------------------------------
// cflvc_front
// Accepts input transactions, clamps and masks the payload, and queues the
// resulting commands for the engine in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none
module cflvc_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire cflvc_pkg::in_item_t in_data,
  output logic                     cmd_valid,
  input  wire logic                cmd_ready,
  output cflvc_pkg::cmd_t          cmd
);
  import cflvc_pkg::*;

  cmd_t            q_r [2];
  logic            wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic [LEN_W-1:0] len_c;
  cmd_t            new_c;
  logic            push, pop;

  // Classify the incoming transaction
  always_comb begin
    len_c = (in_data.length_code > LEN_W'(8)) ? LEN_W'(8) : in_data.length_code;
    new_c.op       = op_t'(in_data.operation);
    new_c.frame_id = in_data.frame_id;
    new_c.ext      = in_data.extended_format;
    new_c.data     = mask_payload(len_c, in_data.payload_in);
  end

  assign in_ready  = (cnt_r != 2'd2);
  assign push      = in_valid && in_ready;
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  // Advance queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= new_c;
  end

endmodule
`default_nettype wire

// ===== rtl/cflvc_engine.sv =====
// ----------------------------------------------------------------------------
// cflvc_engine
// Carries out one command at a time: scans the slot tags one slot at a time,
// each tag registered before the compare, then reads or writes the payload memory and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none
module cflvc_engine #(
  parameter int unsigned CACHE_DEPTH = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cmd_valid,
  output logic                      cmd_ready,
  input  wire cflvc_pkg::cmd_t      cmd,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output cflvc_pkg::out_item_t      out_data
);
  import cflvc_pkg::*;

  localparam int unsigned IW = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(CACHE_DEPTH + 1);

  // Tag storage: id and format per slot, memory without reset
  logic [ID_W-1:0]   id_mem  [CACHE_DEPTH];
  logic              ext_mem [CACHE_DEPTH];
  logic [DATA_W-1:0] pay_mem [CACHE_DEPTH];
  logic [CACHE_DEPTH-1:0] pend_r;

  eng_state_t st_r, st_nxt;
  cmd_t       c_r;
  logic [CW-1:0] used_r;
  logic [IW-1:0] cur_r;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [IW-1:0] hit_r, hit_nxt;
  logic          found_r, found_nxt;
  logic [ID_W-1:0]   rd_id_r;
  logic              rd_ext_r;
  logic [DATA_W-1:0] rd_pay_r;
  logic [IW-1:0]     rd_idx_r;
  logic              rd_ok_r;
  out_item_t         res_r;
  logic              ov_r;
  logic              take;
  logic              match;
  logic              last;
  logic [IW-1:0]     idx_inc;

  assign take      = (st_r == S_IDLE) && cmd_valid && !ov_r;
  assign cmd_ready = take;
  assign out_valid = ov_r;
  assign out_data  = res_r;

  // Compare the tag read in the previous cycle
  always_comb begin
    case (c_r.op)
      OP_STORE: match = (rd_id_r == c_r.frame_id) && (rd_ext_r == c_r.ext);
      OP_RR:    match = pend_r[rd_idx_r];
      OP_REQ:   match = pend_r[rd_idx_r] && (rd_id_r == c_r.frame_id);
      default:  match = 1'b0;
    endcase
    last    = (k_r + CW'(1) >= used_r);
    idx_inc = (CW'(idx_r) + CW'(1) >= used_r) ? '0 : idx_r + IW'(1);
  end

  // Next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE:  if (take) st_nxt = S_SCAN;
      S_SCAN:  begin
        if (c_r.op == OP_NONE || used_r == '0) st_nxt = S_DONE;
        else st_nxt = S_READ;
      end
      S_READ:  begin
        if ((rd_ok_r && match) || (rd_ok_r && last)) st_nxt = S_WRITE;
      end
      S_WRITE: st_nxt = S_DONE;
      S_DONE:  st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  // Scan bookkeeping
  always_comb begin
    idx_nxt   = idx_r;
    k_nxt     = k_r;
    hit_nxt   = hit_r;
    found_nxt = found_r;
    case (st_r)
      S_SCAN: begin
        found_nxt = 1'b0;
        k_nxt     = '0;
        if (c_r.op == OP_RR) idx_nxt = (CW'(cur_r) >= used_r) ? '0 : cur_r;
        else idx_nxt = '0;
      end
      S_READ: begin
        if (rd_ok_r) begin
          if (match) begin
            found_nxt = 1'b1;
            hit_nxt   = rd_idx_r;
          end else if (!last) begin
            k_nxt   = k_r + CW'(1);
            idx_nxt = (c_r.op == OP_RR) ? idx_inc : idx_r + IW'(1);
          end
        end else begin
          k_nxt   = k_r;
        end
      end
      default: ;
    endcase
  end

  // Engine registers and memories
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      pend_r  <= '0;
      used_r  <= '0;
      cur_r   <= '0;
      ov_r    <= 1'b0;
      rd_ok_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      rd_ok_r <= (st_nxt == S_READ) && !((st_r == S_READ) && rd_ok_r);
      if (ov_r && out_ready) ov_r <= 1'b0;
      if (st_r == S_WRITE) begin
        if (c_r.op == OP_STORE) begin
          if (found_r) begin
            pend_r[hit_r] <= 1'b1;
          end else if (used_r < CW'(CACHE_DEPTH)) begin
            pend_r[used_r[IW-1:0]] <= 1'b1;
            used_r <= used_r + CW'(1);
          end
        end else if (found_r) begin
          pend_r[hit_r] <= 1'b0;
          if (c_r.op == OP_RR)
            cur_r <= (CW'(hit_r) + CW'(1) >= used_r) ? '0 : hit_r + IW'(1);
        end
      end
      // Store into an empty table takes slot zero from the scan state
      if (st_r == S_SCAN && c_r.op == OP_STORE && used_r == '0) begin
        pend_r[0] <= 1'b1;
        used_r    <= CW'(1);
      end
      if (st_r == S_DONE) ov_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) c_r <= cmd;
    idx_r   <= idx_nxt;
    k_r     <= k_nxt;
    hit_r   <= hit_nxt;
    found_r <= found_nxt;
    // Registered tag and payload read
    rd_id_r  <= id_mem[idx_nxt];
    rd_ext_r <= ext_mem[idx_nxt];
    rd_pay_r <= pay_mem[(st_r == S_READ && rd_ok_r && match) ? rd_idx_r : idx_nxt];
    rd_idx_r <= idx_nxt;
    if (st_r == S_WRITE && c_r.op == OP_STORE) begin
      if (found_r) begin
        pay_mem[hit_r] <= c_r.data;
      end else if (used_r < CW'(CACHE_DEPTH)) begin
        id_mem[used_r[IW-1:0]]  <= c_r.frame_id;
        ext_mem[used_r[IW-1:0]] <= c_r.ext;
        pay_mem[used_r[IW-1:0]] <= c_r.data;
      end
    end
    // Build the result
    if (st_r == S_WRITE) begin
      res_r.claimed_id      <= '0;
      res_r.claimed_payload <= '0;
      if (c_r.op == OP_STORE) begin
        res_r.status <= (found_r || used_r < CW'(CACHE_DEPTH)) ? ST_OK : ST_FULL;
      end else if (found_r) begin
        res_r.status          <= ST_OK;
        res_r.claimed_id      <= rd_id_r;
        res_r.claimed_payload <= rd_pay_r;
      end else begin
        res_r.status <= ST_NONE;
      end
    end else if (st_r == S_SCAN && (c_r.op == OP_NONE || used_r == '0)) begin
      res_r.claimed_id      <= '0;
      res_r.claimed_payload <= '0;
      res_r.status          <= (c_r.op == OP_STORE) ? ST_OK : ST_NONE;
      if (c_r.op == OP_STORE) begin
        id_mem[0]  <= c_r.frame_id;
        ext_mem[0] <= c_r.ext;
        pay_mem[0] <= c_r.data;
      end
    end
  end

endmodule
`default_nettype wire
